>>> sv/tun_pkg.sv
package tun_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_W      = FRAC_BITS + 2;
  localparam int EDGE_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MAG_W      = CROSS_W - 2;
  localparam int SM_W       = 30;
  localparam int SQ_W       = 2 * SM_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 1;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int NUM_W      = SM_W + QUO_W;
  localparam int DREM_W     = ROOT_W;

  typedef struct packed {
    logic                      valid;
    logic                      degen;
    logic [2:0]                neg;
    logic [2:0][SM_W-1:0]      sm;
  } tun_item_t;

endpackage

>>> sv/tun_front.sv
module tun_front import tun_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by_coord,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] cz,
  output tun_item_t                    item_out,
  output logic [SUM_W-1:0]             sum_out
);

  logic                     v1, v2, v3, v4, v5;
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [PROD_W-1:0] p [3];
  logic signed [PROD_W-1:0] q [3];
  logic [MAG_W-1:0]         mag [3];
  logic [2:0]               neg3;
  logic                     degen3;
  tun_item_t                it4, it5;
  logic [SQ_W-1:0]          sq [3];

  logic signed [CROSS_W-1:0] c [3];
  logic signed [CROSS_W-1:0] cabs [3];
  logic [MAG_W-1:0]          mag_or;
  logic [1:0]                shamt;
  logic [MAG_W-1:0]          shifted [3];

  // cross product and magnitude
  always_comb begin
    c[0] = CROSS_W'(p[0]) - CROSS_W'(q[0]);
    c[1] = CROSS_W'(p[1]) - CROSS_W'(q[1]);
    c[2] = CROSS_W'(p[2]) - CROSS_W'(q[2]);
    for (int i = 0; i < 3; i++) begin
      cabs[i] = c[i][CROSS_W-1] ? -c[i] : c[i];
    end
  end

  // block scaling: keep the largest magnitude below 2^SM_W
  always_comb begin
    mag_or = mag[0] | mag[1] | mag[2];
    if (mag_or[SM_W+2]) begin
      shamt = 2'd3;
    end else if (mag_or[SM_W+1]) begin
      shamt = 2'd2;
    end else if (mag_or[SM_W]) begin
      shamt = 2'd1;
    end else begin
      shamt = 2'd0;
    end
    for (int i = 0; i < 3; i++) begin
      shifted[i] = mag[i] >> shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      it4.valid      <= 1'b0;
      it5.valid      <= 1'b0;
      v4             <= 1'b0;
      v5             <= 1'b0;
      item_out.valid <= 1'b0;
    end else if (en) begin
      v1     <= in_valid;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      v5     <= v4;
      it4.valid <= v3;
      it5.valid <= it4.valid;
      item_out.valid <= v5 & it5.valid;
    end
    if (en) begin
      e1[0] <= EDGE_W'(bx) - EDGE_W'(ax);
      e1[1] <= EDGE_W'(by_coord) - EDGE_W'(ay);
      e1[2] <= EDGE_W'(bz) - EDGE_W'(az);
      e2[0] <= EDGE_W'(cx) - EDGE_W'(ax);
      e2[1] <= EDGE_W'(cy) - EDGE_W'(ay);
      e2[2] <= EDGE_W'(cz) - EDGE_W'(az);
      p[0] <= PROD_W'(e1[1]) * PROD_W'(e2[2]);
      q[0] <= PROD_W'(e1[2]) * PROD_W'(e2[1]);
      p[1] <= PROD_W'(e1[2]) * PROD_W'(e2[0]);
      q[1] <= PROD_W'(e1[0]) * PROD_W'(e2[2]);
      p[2] <= PROD_W'(e1[0]) * PROD_W'(e2[1]);
      q[2] <= PROD_W'(e1[1]) * PROD_W'(e2[0]);
      for (int i = 0; i < 3; i++) begin
        mag[i]  <= cabs[i][MAG_W-1:0];
        neg3[i] <= c[i][CROSS_W-1];
      end
      degen3 <= (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
      it4.degen <= degen3;
      it4.neg   <= neg3;
      for (int i = 0; i < 3; i++) begin
        it4.sm[i] <= shifted[i][SM_W-1:0];
        sq[i]     <= SQ_W'(it4.sm[i]) * SQ_W'(it4.sm[i]);
      end
      it5.degen <= it4.degen;
      it5.neg   <= it4.neg;
      it5.sm    <= it4.sm;
      sum_out   <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      item_out.degen <= it5.degen;
      item_out.neg   <= it5.neg;
      item_out.sm    <= it5.sm;
    end
  end

endmodule

>>> sv/tun_sqrt.sv
module tun_sqrt import tun_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tun_item_t         item_in,
  input  logic [SUM_W-1:0]  sum_in,
  output tun_item_t         item_out,
  output logic [ROOT_W-1:0] root_out
);

  logic [REM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  logic [SUM_W-1:0]  x    [ROOT_W+1];
  tun_item_t         it   [ROOT_W+1];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign x[0]    = sum_in;
  assign it[0]   = item_in;

  // one root bit per stage, two radicand bits consumed
  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [REM_W+1:0] remsh;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
      remsh = {rem[j], x[j][SUM_W-1 -: 2]};
      trial = (REM_W+2)'({root[j], 2'b01});
      ge    = remsh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it[j+1] <= '0;
      end else if (en) begin
        it[j+1] <= it[j];
      end
      if (en) begin
        rem[j+1]  <= ge ? REM_W'(remsh - trial) : REM_W'(remsh);
        root[j+1] <= {root[j][ROOT_W-2:0], ge};
        x[j+1]    <= x[j] << 2;
      end
    end
  end

  assign item_out = it[ROOT_W];
  assign root_out = root[ROOT_W];

endmodule

>>> sv/tun_div.sv
module tun_div import tun_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  tun_item_t                 item_in,
  input  logic [ROOT_W-1:0]         len_in,
  output logic                      valid_out,
  output logic                      degen_out,
  output logic [2:0]                neg_out,
  output logic [2:0][QUO_W-1:0]     quo_out
);

  logic [ROOT_W-1:0]             len  [QUO_W+1];
  logic [2:0][DREM_W-1:0]        rem  [QUO_W+1];
  logic [2:0][QUO_W-1:0]         low  [QUO_W+1];
  logic [2:0][QUO_W-1:0]         quo  [QUO_W+1];
  logic                          vld  [QUO_W+1];
  logic                          dgn  [QUO_W+1];
  logic [2:0]                    sgn  [QUO_W+1];
  logic [2:0][NUM_W-1:0]         num;
  logic [ROOT_W-1:0]             len_nz;

  // numerator with half-divisor rounding term; quotient fits QUO_W bits
  always_comb begin
    len_nz = (len_in == '0) ? ROOT_W'(1) : len_in;
    for (int i = 0; i < 3; i++) begin
      num[i] = {item_in.sm[i], {FRAC_BITS{1'b0}}} + NUM_W'(len_nz >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= item_in.valid;
    end
    if (en) begin
      len[0] <= len_nz;
      dgn[0] <= item_in.degen;
      sgn[0] <= item_in.neg;
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= DREM_W'(num[i][NUM_W-1:QUO_W]);
        low[0][i] <= num[i][QUO_W-1:0];
        quo[0][i] <= '0;
      end
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [2:0][DREM_W:0] remsh;
    logic [2:0]           ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        remsh[i] = {rem[j][i], low[j][i][QUO_W-1]};
        ge[i]    = remsh[i] >= (DREM_W+1)'(len[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        len[j+1] <= len[j];
        dgn[j+1] <= dgn[j];
        sgn[j+1] <= sgn[j];
        for (int i = 0; i < 3; i++) begin
          rem[j+1][i] <= ge[i] ? DREM_W'(remsh[i] - (DREM_W+1)'(len[j]))
                               : DREM_W'(remsh[i]);
          low[j+1][i] <= low[j][i] << 1;
          quo[j+1][i] <= {quo[j][i][QUO_W-2:0], ge[i]};
        end
      end
    end
  end

  assign valid_out = vld[QUO_W];
  assign degen_out = dgn[QUO_W];
  assign neg_out   = sgn[QUO_W];
  assign quo_out   = quo[QUO_W];

endmodule

>>> sv/triangle_unit_normal_core.sv
// Unit face normal of a triangle. Each transfer on the input channel carries
// three vertices in signed Q3.12; each transfer on the output channel carries
// the normalized cross product (B-A) x (C-A) in signed Q1.14 and a degenerate
// flag, which is set with an all-zero normal when the cross product is zero.
// One triangle is accepted per clock while in_stall is low; results leave in
// input order through 6 front stages (edges, products, cross, scale,
// squares, sum), 31 square-root stages (one root bit each), 16 divider stages
// (setup plus one quotient bit each) and the output register. The pipeline
// keeps moving while a result waits as long as no finished item would
// collide with it.
module triangle_unit_normal_core import tun_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by_coord,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] cz,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_W-1:0]      normal_x,
  output logic signed [OUT_W-1:0]      normal_y,
  output logic signed [OUT_W-1:0]      normal_z,
  output logic                         degenerate
);

  logic                  en;
  logic                  load;
  tun_item_t             front_item;
  logic [SUM_W-1:0]      front_sum;
  tun_item_t             sqrt_item;
  logic [ROOT_W-1:0]     sqrt_root;
  logic                  div_valid;
  logic                  div_degen;
  logic [2:0]            div_neg;
  logic [2:0][QUO_W-1:0] div_quo;
  logic [2:0][OUT_W-1:0] signed_q;

  // output register free or being drained this cycle
  assign load = !out_valid || !out_stall;
  // the whole pipeline shifts unless a finished item would hit a held result
  assign en       = load || !div_valid;
  assign in_stall = !en;

  tun_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .ax       (ax),
    .ay       (ay),
    .az       (az),
    .bx       (bx),
    .by_coord (by_coord),
    .bz       (bz),
    .cx       (cx),
    .cy       (cy),
    .cz       (cz),
    .item_out (front_item),
    .sum_out  (front_sum)
  );

  // floor square root of the sum of squares gives the length
  tun_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .item_in  (front_item),
    .sum_in   (front_sum),
    .item_out (sqrt_item),
    .root_out (sqrt_root)
  );

  // three rounded divisions by the length, side by side
  tun_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .item_in   (sqrt_item),
    .len_in    (sqrt_root),
    .valid_out (div_valid),
    .degen_out (div_degen),
    .neg_out   (div_neg),
    .quo_out   (div_quo)
  );

  // apply the sign of each cross component
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      signed_q[i] = div_neg[i] ? -OUT_W'(div_quo[i]) : OUT_W'(div_quo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= div_valid;
    end
    if (load) begin
      normal_x   <= div_degen ? '0 : signed_q[0];
      normal_y   <= div_degen ? '0 : signed_q[1];
      normal_z   <= div_degen ? '0 : signed_q[2];
      degenerate <= div_degen;
    end
  end

endmodule

>>> sim/triangle_unit_normal_core_test.sv
module triangle_unit_normal_core_test;
  import tun_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]      norm_t;

  typedef struct {
    norm_t nx, ny, nz;
    logic  degen;
  } normal_t;

  typedef struct {
    coord_t  v[9];
    bit      typed;
    normal_t want;
  } tri_row_t;

  logic   clk, rst;
  logic   in_valid, in_stall, out_valid, out_stall;
  coord_t ax, ay, az, bx, by_coord, bz, cx, cy, cz;
  norm_t  normal_x, normal_y, normal_z;
  logic   degenerate;

  normal_t normal_q[$];
  normal_t cur_want;
  bit      cur_typed;
  bit      calm;
  int      errors;

  triangle_unit_normal_core u_top (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit face normal of (B-A) x (C-A), block scaled to 30 bits
  function automatic normal_t face_normal(coord_t v[9]);
    normal_t         res;
    longint          e1[3], e2[3], cr[3];
    longint unsigned m[3], sum, len, q;
    int              s;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(v[3+i]) - longint'(v[i]);
      e2[i] = longint'(v[6+i]) - longint'(v[i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    res = '{0, 0, 0, 1'b0};
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      res.degen = 1'b1;
      return res;
    end
    for (int i = 0; i < 3; i++) m[i] = cr[i] < 0 ? -cr[i] : cr[i];
    s = 0;
    while ((m[0] >> s) >= (64'd1 << SM_W) || (m[1] >> s) >= (64'd1 << SM_W) ||
           (m[2] >> s) >= (64'd1 << SM_W))
      s++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> s;
      sum += m[i] * m[i];
    end
    len = floor_sqrt(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
      if (cr[i] < 0) q = -q;
      if (i == 0) res.nx = q[OUT_W-1:0];
      else if (i == 1) res.ny = q[OUT_W-1:0];
      else res.nz = q[OUT_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // send one triangle, with random idle cycles ahead of it
  task automatic send_triangle(tri_row_t row);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    {ax, ay, az, bx, by_coord, bz, cx, cy, cz} =
      {row.v[0], row.v[1], row.v[2], row.v[3], row.v[4], row.v[5],
       row.v[6], row.v[7], row.v[8]};
    cur_typed = row.typed;
    cur_want  = row.want;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom_range(255)) - 128;
      1: return coord_t'($urandom_range(8191)) - 4096;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // expectations are taken at each input transfer, checked at each output transfer
  always @(posedge clk) begin
    normal_t w;
    if (!rst && in_valid && !in_stall) begin
      normal_q.push_back(cur_typed ? cur_want
        : face_normal('{ax, ay, az, bx, by_coord, bz, cx, cy, cz}));
    end
    if (!rst && out_valid && !out_stall) begin
      if (normal_q.size() == 0) begin
        $display("output transfer with nothing expected");
        errors++;
      end else begin
        w = normal_q.pop_front();
        if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
        if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
        if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, w.nz);
        if (degenerate !== w.degen) report_mismatch("degenerate", degenerate, w.degen);
      end
    end
  end

  // receiver stalls at random outside the calm window
  always @(negedge clk)
    out_stall <= (!calm && $urandom_range(99) < 33);

  initial begin
    #400000;
    $display("triangle_unit_normal_core test failed");
    $finish;
  end

  initial begin
    tri_row_t tbl[$];
    tri_row_t row;
    coord_t   k;
    int       mode;
    errors = 0;
    calm = 1'b0;
    cur_typed = 1'b0;
    cur_want = '{0, 0, 0, 1'b0};
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {ax, ay, az, bx, by_coord, bz, cx, cy, cz} = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed rows: degenerate cases, axis-aligned normals, extremes
    tbl.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1'b1}});
    tbl.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768}, 1, '{0, 0, 0, 1'b1}});
    tbl.push_back('{'{5, 7, 9, 10, 14, 18, 15, 21, 27}, 1, '{0, 0, 0, 1'b1}});
    tbl.push_back('{'{0, 0, 0, 4096, 0, 0, 0, 4096, 0}, 1, '{0, 0, 16384, 1'b0}});
    tbl.push_back('{'{0, 0, 0, 0, 4096, 0, 4096, 0, 0}, 1, '{0, 0, -16384, 1'b0}});
    tbl.push_back('{'{0, 0, 0, 0, 4096, 0, 0, 0, 4096}, 1, '{16384, 0, 0, 1'b0}});
    tbl.push_back('{'{0, 0, 0, 0, 0, 4096, 4096, 0, 0}, 1, '{0, 16384, 0, 1'b0}});
    tbl.push_back('{'{-32768, -32768, -32768, 32767, -32768, -32768,
                      -32768, 32767, -32768}, 1, '{0, 0, 16384, 1'b0}});
    tbl.push_back('{'{32767, 32767, 32767, -32768, 32767, 32767,
                      32767, 32767, -32768}, 0, '{0, 0, 0, 1'b0}});
    tbl.push_back('{'{-32768, 32767, -32768, 32767, -32768, 32767,
                      -32768, -32768, 32767}, 0, '{0, 0, 0, 1'b0}});
    tbl.push_back('{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1, '{0, 0, 16384, 1'b0}});
    tbl.push_back('{'{0, 0, 0, 1, 1, 0, 0, 1, 1}, 0, '{0, 0, 0, 1'b0}});
    tbl.push_back('{'{100, -200, 300, -32768, 32767, 0, 32767, 0, -32768},
                    0, '{0, 0, 0, 1'b0}});
    foreach (tbl[i]) send_triangle(tbl[i]);

    for (int n = 0; n < 1050; n++) begin
      calm = (n >= 300 && n < 500);
      row.typed = 1'b0;
      mode = $urandom_range(2);
      for (int j = 0; j < 9; j++) row.v[j] = rnd_coord(mode);
      case ($urandom_range(9))
        0: begin
          // collinear vertices: C = A + k (B - A)
          k = coord_t'($urandom_range(6)) - 3;
          for (int j = 0; j < 3; j++) begin
            row.v[j]   = rnd_coord(0);
            row.v[3+j] = rnd_coord(0);
            row.v[6+j] = row.v[j] + k * (row.v[3+j] - row.v[j]);
          end
        end
        1: for (int j = 0; j < 3; j++) row.v[3+j] = row.v[j];
        default: ;
      endcase
      send_triangle(row);
    end
    in_valid = 1'b0;
    calm = 1'b0;

    while (normal_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("triangle_unit_normal_core test passed");
    else
      $display("triangle_unit_normal_core test failed");
    $finish;
  end

endmodule
